// File: hdl/tmsu_pkg.sv
// Package for the test mode sequencer unit.
// Holds the shared types, codes and timing constants; depends on nothing.

package tmsu_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);

    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    localparam int PIN_IO = 0;
    localparam int PIN_DRIVE = 1;
    localparam int PIN_LED = 2;
    localparam int PIN_GREEN = 3;
    localparam int PIN_BLUE = 4;
    localparam int PIN_W = 5;

    localparam logic [1:0] PHASE_BLANK = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_TEMP_LIMIT = 1'b1;

    localparam logic [7:0] TIMEOUT_RESET = 8'd60;
    localparam logic [9:0] TEMP_LIMIT_RESET = 10'd60;

    typedef enum logic [2:0]
    {
        MODE_OFF = 3'd0,
        MODE_REF = 3'd1,
        MODE_IO = 3'd2,
        MODE_SHUNT = 3'd3,
        MODE_BLINK = 3'd4
    } mode_t;

    typedef struct packed
    {
        logic       operation;
        logic [2:0] mode;
        logic [7:0] shunt_level;
        logic [9:0] temperature;
    } item_t;

    typedef struct packed
    {
        logic [7:0] timeout_seconds;
        logic [9:0] temp_limit;
    } cfg_t;

    typedef struct packed
    {
        logic [2:0] status;
        logic       io_on;
        logic       shunt_drive_on;
        logic [7:0] shunt_drive_level;
        logic       shunt_led_on;
        logic       green_lit;
        logic       blue_on;
    } res_t;

    function automatic logic [9:0] phase_ticks(input logic [1:0] phase);
        logic [9:0] ticks;
        case (phase)
            2'd0:    ticks = 10'd50;
            2'd1:    ticks = 10'd100;
            2'd2:    ticks = 10'd100;
            default: ticks = 10'd750;
        endcase
        return ticks;
    endfunction

    function automatic logic [PIN_W-1:0] phase_pin(input logic [1:0] phase);
        logic [PIN_W-1:0] pins;
        pins = '0;
        case (phase)
            2'd0:    pins[PIN_LED] = 1'b1;
            2'd1:    pins[PIN_GREEN] = 1'b1;
            2'd2:    pins[PIN_BLUE] = 1'b1;
            default: pins = '0;
        endcase
        return pins;
    endfunction

endpackage

// File: hdl/tmsu_engine.sv
// Mode state, second timer and blink sequencer of the test mode sequencer unit.
// Takes one registered request per step and returns the result it causes; uses tmsu_pkg.

module tmsu_engine
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  tmsu_pkg::item_t item,
    input  tmsu_pkg::cfg_t  cfg,
    output tmsu_pkg::res_t  result
);

    tmsu_pkg::mode_t                    mode_reg, mode_next;
    logic [tmsu_pkg::TICK_W-1:0]        tick_reg, tick_next;
    logic [7:0]                         seconds_reg, seconds_next;
    logic [1:0]                         phase_reg, phase_next;
    logic [9:0]                         remaining_reg, remaining_next;
    logic [tmsu_pkg::PIN_W-1:0]         pins_reg, pins_next;
    logic [7:0]                         level_reg, level_next;
    logic [tmsu_pkg::TICK_W-1:0]        tick_inc;
    logic                               timed_out;

    always_comb
    begin
        mode_next = mode_reg;
        tick_next = tick_reg;
        seconds_next = seconds_reg;
        phase_next = phase_reg;
        remaining_next = remaining_reg;
        pins_next = pins_reg;
        level_next = level_reg;
        tick_inc = tick_reg + 1'b1;
        timed_out = 1'b0;

        if (item.operation == tmsu_pkg::OP_START)
        begin
            seconds_next = '0;
            tick_next = '0;
            unique case (item.mode)
                tmsu_pkg::MODE_REF:
                begin
                    mode_next = tmsu_pkg::MODE_REF;
                end
                tmsu_pkg::MODE_IO:
                begin
                    mode_next = tmsu_pkg::MODE_IO;
                    pins_next[tmsu_pkg::PIN_IO] = 1'b1;
                end
                tmsu_pkg::MODE_SHUNT:
                begin
                    mode_next = tmsu_pkg::MODE_SHUNT;
                    pins_next[tmsu_pkg::PIN_DRIVE] = 1'b1;
                    level_next = item.shunt_level;
                end
                tmsu_pkg::MODE_BLINK:
                begin
                    mode_next = tmsu_pkg::MODE_BLINK;
                    phase_next = tmsu_pkg::PHASE_BLANK;
                    remaining_next = tmsu_pkg::phase_ticks(tmsu_pkg::PHASE_BLANK);
                end
                default:
                begin
                    mode_next = tmsu_pkg::MODE_OFF;
                    pins_next = '0;
                    level_next = '0;
                end
            endcase
        end
        else if (mode_reg == tmsu_pkg::MODE_OFF)
        begin
            pins_next = '0;
            level_next = '0;
        end
        else
        begin
            tick_next = tick_inc;
            if (32'(tick_inc) >= 32'(tmsu_pkg::TICKS_PER_SECOND))
            begin
                tick_next = '0;
                seconds_next = seconds_reg + 8'd1;
                timed_out = (seconds_next >= cfg.timeout_seconds);
            end

            if (timed_out)
            begin
                mode_next = tmsu_pkg::MODE_OFF;
                pins_next = '0;
                level_next = '0;
            end
            else if (mode_reg == tmsu_pkg::MODE_BLINK)
            begin
                if (remaining_reg <= 10'd1)
                begin
                    phase_next = phase_reg + 2'd1;
                    remaining_next = tmsu_pkg::phase_ticks(phase_next);
                    pins_next[tmsu_pkg::PIN_LED] = 1'b0;
                    pins_next[tmsu_pkg::PIN_GREEN] = 1'b0;
                    pins_next[tmsu_pkg::PIN_BLUE] = 1'b0;
                    pins_next = pins_next | tmsu_pkg::phase_pin(phase_next);
                end
                else
                begin
                    remaining_next = remaining_reg - 10'd1;
                end
            end
            else if (mode_reg == tmsu_pkg::MODE_SHUNT)
            begin
                if (item.temperature > cfg.temp_limit)
                begin
                    mode_next = tmsu_pkg::MODE_OFF;
                    pins_next = '0;
                    level_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tmsu_pkg::MODE_OFF;
            tick_reg <= '0;
            seconds_reg <= '0;
            phase_reg <= tmsu_pkg::PHASE_BLANK;
            remaining_reg <= '0;
            pins_reg <= '0;
            level_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            tick_reg <= tick_next;
            seconds_reg <= seconds_next;
            phase_reg <= phase_next;
            remaining_reg <= remaining_next;
            pins_reg <= pins_next;
            level_reg <= level_next;
        end
    end

    assign result.status = mode_next;
    assign result.io_on = pins_next[tmsu_pkg::PIN_IO];
    assign result.shunt_drive_on = pins_next[tmsu_pkg::PIN_DRIVE];
    assign result.shunt_drive_level = level_next;
    assign result.shunt_led_on = pins_next[tmsu_pkg::PIN_LED];
    assign result.green_lit = pins_next[tmsu_pkg::PIN_GREEN];
    assign result.blue_on = pins_next[tmsu_pkg::PIN_BLUE];

endmodule

// File: hdl/test_mode_sequencer_unit.sv
// Top level of the test mode sequencer unit: input register, configuration
// registers, output register and the tmsu_engine instance; uses tmsu_pkg.
//
// Channel   Direction  Signals                         Content
// s         in         s_tvalid s_tready s_tdata s_tuser  start or tick request
// m         out        m_tvalid m_tready m_tdata          one result per request
// cfg       in         cfg_we cfg_index cfg_data          register write
//
// A request is taken into the input register, worked by tmsu_engine and the
// result lands in the output register. One request is accepted in every
// cycle while no stall holds it; the output register stalls while a result
// waits and m_tready is low, the input register only if it also holds one.
// Reset clears all control state, sets the blink phase to blank and loads the
// register reset values.

module test_mode_sequencer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mode [2:0], shunt_level [10:3], temperature [20:11], zero [23:21]
    input  logic [tmsu_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status [2:0], io_on [3], shunt_drive_on [4], shunt_drive_level [12:5],
    // shunt_led_on [13], green_lit [14], blue_on [15]
    output logic [tmsu_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [9:0]                         cfg_data
);

    tmsu_pkg::item_t  item_reg;
    logic             in_valid_reg;
    tmsu_pkg::res_t   res_reg;
    logic             out_valid_reg;
    tmsu_pkg::cfg_t   cfg_reg;
    tmsu_pkg::res_t   result;
    logic             advance;
    logic             fire;

    assign advance = !out_valid_reg || m_tready;
    assign fire = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.timeout_seconds <= tmsu_pkg::TIMEOUT_RESET;
            cfg_reg.temp_limit <= tmsu_pkg::TEMP_LIMIT_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    tmsu_pkg::REG_TIMEOUT:    cfg_reg.timeout_seconds <= cfg_data[7:0];
                    tmsu_pkg::REG_TEMP_LIMIT: cfg_reg.temp_limit <= cfg_data;
                    default:                  cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.operation <= s_tuser;
            item_reg.mode <= s_tdata[2:0];
            item_reg.shunt_level <= s_tdata[10:3];
            item_reg.temperature <= s_tdata[20:11];
        end
        if (fire)
        begin
            res_reg <= result;
        end
    end

    tmsu_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {res_reg.blue_on, res_reg.green_lit, res_reg.shunt_led_on,
                      res_reg.shunt_drive_level, res_reg.shunt_drive_on,
                      res_reg.io_on, res_reg.status};

endmodule
